@@ hdl/obl_pkg.sv @@
// Package for the order book level insert block.
// Holds the default sizes, field widths and the controller to datapath
// command and status types. No dependencies.
package obl_pkg;

    localparam int TICKS_DEF = 4096;
    localparam int DEPTH_DEF = 16;
    localparam int BM_W      = 64;
    localparam int BM_BW     = 6;
    localparam int TICK_W    = 12;
    localparam int ID_W      = 32;
    localparam int BEST_W    = 13;
    localparam int CNT_W     = 5;
    localparam int PTR_W     = 16;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_EMPTY = 1'b1;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic clr;
        logic load;
        logic lookup;
        logic update;
        logic scan_rd;
        logic scan_chk;
        logic ld_out;
    } obl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic need_scan;
        logic scan_done;
    } obl_sts_t;

endpackage

@@ hdl/obl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module obl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/obl_ctrl.sv @@
// Controller state machine of the order book level insert block.
// Sequences clearing, lookup, update, rescan and result hand-off; uses obl_pkg.
module obl_ctrl
    import obl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  obl_sts_t  sts,
    output obl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        cmd.clr      = (state_reg == ST_CLEAR);
        cmd.load     = (state_reg == ST_IDLE) && s_valid;
        cmd.lookup   = (state_reg == ST_LOOKUP);
        cmd.update   = (state_reg == ST_UPDATE);
        cmd.scan_rd  = (state_reg == ST_SCAN_RD);
        cmd.scan_chk = (state_reg == ST_SCAN_CHK);
        cmd.ld_out   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:   state_next = ST_UPDATE;
            ST_UPDATE:   state_next = sts.need_scan ? ST_SCAN_RD : ST_DONE;
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: state_next = sts.scan_done ? ST_DONE : ST_SCAN_RD;
            ST_DONE: begin
                if (cmd.ld_out) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.ld_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ hdl/obl_dp.sv @@
// Datapath of the order book level insert block: present bitmap, level
// pointers, order store, best prices and the rescan unit. Uses obl_pkg, obl_ram.
module obl_dp
    import obl_pkg::*;
#(
    parameter int TICKS       = TICKS_DEF,
    parameter int LEVEL_DEPTH = DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  obl_cmd_t                 cmd,
    output obl_sts_t                 sts,
    input  logic                     s_action,
    input  logic                     s_side,
    input  logic [TICK_W-1:0]        s_price_index,
    input  logic [ID_W-1:0]          s_order_id,
    output logic signed [BEST_W-1:0] m_high_bid,
    output logic signed [BEST_W-1:0] m_low_ask,
    output logic [CNT_W-1:0]         m_level_count,
    output logic                     m_dropped_oldest
);

    localparam int WORDS  = (TICKS + BM_W - 1) / BM_W;
    localparam int ROWS   = 2 * WORDS;
    localparam int RAW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WB     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LVLS   = 2 * TICKS;
    localparam int LVW    = $clog2(LVLS);
    localparam int PB     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int OSD    = LVLS * LEVEL_DEPTH;
    localparam int OSW    = $clog2(OSD);
    localparam int HT_W   = PB + 2 * PTR_W;

    logic                     action_reg;
    logic                     side_reg;
    logic [TICK_W-1:0]        tick_reg;
    logic [ID_W-1:0]          id_reg;
    logic signed [BEST_W-1:0] high_bid_reg;
    logic signed [BEST_W-1:0] low_ask_reg;
    logic [PTR_W-1:0]         count_reg;
    logic                     drop_reg;
    logic [RAW-1:0]           clr_cnt_reg;
    logic [WB-1:0]            sw_reg;
    logic [BM_BW-1:0]         thr_reg;
    logic                     first_reg;

    logic                     in_range;
    logic [LVW-1:0]           lv;
    logic [RAW-1:0]           row;
    logic [RAW-1:0]           scan_row;
    logic [BM_BW-1:0]         bitpos;
    logic [BM_W-1:0]          bm_rdata;
    logic [BM_W-1:0]          bm_wdata;
    logic [RAW-1:0]           bm_raddr;
    logic [RAW-1:0]           bm_waddr;
    logic                     bm_we;
    logic [HT_W-1:0]          ht_rdata;
    logic [HT_W-1:0]          ht_wdata;
    logic                     add_we;
    logic [OSW-1:0]           os_waddr;
    logic                     present;
    logic [PTR_W-1:0]         head_rd;
    logic [PTR_W-1:0]         tail_rd;
    logic [PB-1:0]            pos_rd;
    logic [PTR_W-1:0]         head_cur;
    logic [PTR_W-1:0]         tail_cur;
    logic [PB-1:0]            pos_cur;
    logic                     full;
    logic [PTR_W-1:0]         head_new;
    logic [PTR_W-1:0]         tail_new;
    logic [PB-1:0]            pos_new;
    logic signed [BEST_W-1:0] tick_s;
    logic                     match_buy;
    logic                     match_sell;
    logic                     edge_buy;
    logic                     edge_sell;
    logic [TICK_W-1:0]        tick_dn;
    logic [TICK_W:0]          tick_up;
    logic [BM_W-1:0]          masked;
    logic                     hit;
    logic [BM_BW-1:0]         hit_idx;
    logic                     last_word;

    assign in_range = (32'(tick_reg) < TICKS);
    assign lv       = LVW'(side_reg ? TICKS : 0) + LVW'(tick_reg);
    assign row      = RAW'(side_reg ? WORDS : 0) + RAW'(tick_reg >> BM_BW);
    assign scan_row = RAW'(side_reg ? WORDS : 0) + RAW'(sw_reg);
    assign bitpos   = tick_reg[BM_BW-1:0];

    assign add_we   = cmd.update && in_range && (action_reg == ACT_ADD);
    assign bm_we    = cmd.clr || add_we;
    assign bm_waddr = cmd.clr ? clr_cnt_reg : row;
    assign bm_wdata = cmd.clr ? '0 : (bm_rdata | (BM_W'(1) << bitpos));
    assign bm_raddr = cmd.scan_rd ? scan_row : row;

    obl_ram #(.WIDTH(BM_W), .DEPTH(ROWS)) u_bm_ram (
        .aclk  (aclk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    assign present = bm_rdata[bitpos];
    assign head_rd = ht_rdata[PTR_W-1:0];
    assign tail_rd = ht_rdata[2*PTR_W-1:PTR_W];
    assign pos_rd  = ht_rdata[HT_W-1:2*PTR_W];

    always_comb begin
        head_cur = present ? head_rd : '0;
        tail_cur = present ? tail_rd : '0;
        pos_cur  = present ? pos_rd : '0;
        full     = PTR_W'(tail_cur - head_cur) >= PTR_W'(LEVEL_DEPTH);
        head_new = full ? PTR_W'(head_cur + 1'b1) : head_cur;
        tail_new = PTR_W'(tail_cur + 1'b1);
        if ((tail_cur == '1) || (pos_cur == PB'(LEVEL_DEPTH - 1))) begin
            pos_new = '0;
        end else begin
            pos_new = PB'(pos_cur + 1'b1);
        end
    end

    assign ht_wdata = {pos_new, tail_new, head_new};
    assign os_waddr = OSW'(lv) * OSW'(LEVEL_DEPTH) + OSW'(pos_cur);

    obl_ram #(.WIDTH(HT_W), .DEPTH(LVLS)) u_ht_ram (
        .aclk  (aclk),
        .we    (add_we),
        .waddr (lv),
        .wdata (ht_wdata),
        .raddr (lv),
        .rdata (ht_rdata)
    );

    obl_ram #(.WIDTH(ID_W), .DEPTH(OSD)) u_os_ram (
        .aclk  (aclk),
        .we    (add_we),
        .waddr (os_waddr),
        .wdata (id_reg),
        .raddr ('0),
        .rdata ()
    );

    assign tick_s     = signed'(BEST_W'(tick_reg));
    assign match_buy  = (side_reg == SIDE_BUY) && (high_bid_reg == tick_s);
    assign match_sell = (side_reg == SIDE_SELL) && (low_ask_reg == tick_s);
    assign edge_buy   = (tick_reg == '0);
    assign edge_sell  = (32'(tick_reg) + 1 >= TICKS);
    assign tick_dn    = TICK_W'(tick_reg - 1'b1);
    assign tick_up    = (TICK_W + 1)'(tick_reg) + 1'b1;

    always_comb begin
        masked = '0;
        for (int i = 0; i < BM_W; i++) begin
            if (side_reg == SIDE_BUY) begin
                masked[i] = bm_rdata[i] && (!first_reg || (BM_BW'(i) <= thr_reg));
            end else begin
                masked[i] = bm_rdata[i] && (!first_reg || (BM_BW'(i) >= thr_reg));
            end
        end
        hit     = |masked;
        hit_idx = '0;
        if (side_reg == SIDE_BUY) begin
            for (int i = 0; i < BM_W; i++) begin
                if (masked[i]) begin
                    hit_idx = BM_BW'(i);
                end
            end
        end else begin
            for (int i = BM_W - 1; i >= 0; i--) begin
                if (masked[i]) begin
                    hit_idx = BM_BW'(i);
                end
            end
        end
        last_word = (side_reg == SIDE_BUY) ? (sw_reg == '0) : (sw_reg == WB'(WORDS - 1));
    end

    assign sts.clr_last  = (clr_cnt_reg == RAW'(ROWS - 1));
    assign sts.need_scan = in_range && (action_reg == ACT_EMPTY)
                        && ((match_buy && !edge_buy) || (match_sell && !edge_sell));
    assign sts.scan_done = hit || last_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            high_bid_reg <= '1;
            low_ask_reg  <= '1;
        end else begin
            if (cmd.clr) begin
                clr_cnt_reg <= RAW'(clr_cnt_reg + 1'b1);
            end
            if (cmd.load) begin
                action_reg <= s_action;
                side_reg   <= s_side;
                tick_reg   <= s_price_index;
                id_reg     <= s_order_id;
            end
            if (cmd.update) begin
                drop_reg  <= 1'b0;
                count_reg <= '0;
                first_reg <= 1'b1;
                if (side_reg == SIDE_BUY) begin
                    sw_reg  <= WB'(tick_dn >> BM_BW);
                    thr_reg <= tick_dn[BM_BW-1:0];
                end else begin
                    sw_reg  <= WB'(tick_up >> BM_BW);
                    thr_reg <= tick_up[BM_BW-1:0];
                end
                if (in_range) begin
                    if (action_reg == ACT_ADD) begin
                        drop_reg  <= full;
                        count_reg <= PTR_W'(tail_new - head_new);
                        if (side_reg == SIDE_BUY) begin
                            if (high_bid_reg < tick_s) begin
                                high_bid_reg <= tick_s;
                            end
                        end else if (low_ask_reg == '1 || low_ask_reg > tick_s) begin
                            low_ask_reg <= tick_s;
                        end
                    end else begin
                        count_reg <= present ? PTR_W'(tail_rd - head_rd) : '0;
                        if (match_buy && edge_buy) begin
                            high_bid_reg <= '1;
                        end
                        if (match_sell && edge_sell) begin
                            low_ask_reg <= '1;
                        end
                    end
                end
            end
            if (cmd.scan_chk) begin
                first_reg <= 1'b0;
                if (hit) begin
                    if (side_reg == SIDE_BUY) begin
                        high_bid_reg <= signed'(BEST_W'({sw_reg, hit_idx}));
                    end else begin
                        low_ask_reg <= signed'(BEST_W'({sw_reg, hit_idx}));
                    end
                end else if (last_word) begin
                    if (side_reg == SIDE_BUY) begin
                        high_bid_reg <= '1;
                    end else begin
                        low_ask_reg <= '1;
                    end
                end else if (side_reg == SIDE_BUY) begin
                    sw_reg <= WB'(sw_reg - 1'b1);
                end else begin
                    sw_reg <= WB'(sw_reg + 1'b1);
                end
            end
            if (cmd.ld_out) begin
                m_high_bid       <= high_bid_reg;
                m_low_ask        <= low_ask_reg;
                m_level_count    <= count_reg[CNT_W-1:0];
                m_dropped_oldest <= drop_reg;
            end
        end
    end

endmodule

@@ hdl/order_book_level_insert_best_price_core.sv @@
// A transaction is accepted in the idle state, passes through the lookup and update states
// and waits in the done state until the output register is free; a level-empty transaction
// at the best price adds a read and a check step per 64-tick bitmap word scanned through
// the bitmap RAM. One transaction is in flight at a time; the next is accepted while a
// result waits. After reset the present bitmap is cleared, one row per cycle (128 rows
// with the default sizes), before the first transaction is accepted.
// Top level: instantiates obl_ctrl and obl_dp; uses obl_pkg.
module order_book_level_insert_best_price_core
    import obl_pkg::*;
#(
    parameter int TICKS       = TICKS_DEF,
    parameter int LEVEL_DEPTH = DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_action,
    input  logic                     s_side,
    input  logic [TICK_W-1:0]        s_price_index,
    input  logic [ID_W-1:0]          s_order_id,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [BEST_W-1:0] m_high_bid,
    output logic signed [BEST_W-1:0] m_low_ask,
    output logic [CNT_W-1:0]         m_level_count,
    output logic                     m_dropped_oldest
);

    obl_cmd_t cmd;
    obl_sts_t sts;

    obl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    obl_dp #(.TICKS(TICKS), .LEVEL_DEPTH(LEVEL_DEPTH)) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_action         (s_action),
        .s_side           (s_side),
        .s_price_index    (s_price_index),
        .s_order_id       (s_order_id),
        .m_high_bid       (m_high_bid),
        .m_low_ask        (m_low_ask),
        .m_level_count    (m_level_count),
        .m_dropped_oldest (m_dropped_oldest)
    );

endmodule

@@ tb/sv/obl_checker.sv @@
// Checker for the order book level insert block: watches both channels,
// predicts each result from its own copy of the book and compares field by field.
// Depends on obl_pkg.
module obl_checker
    import obl_pkg::*;
#(
    parameter int TICKS       = TICKS_DEF,
    parameter int LEVEL_DEPTH = DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_action,
    input  logic                     s_side,
    input  logic [TICK_W-1:0]        s_price_index,
    input  logic [ID_W-1:0]          s_order_id,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [BEST_W-1:0] m_high_bid,
    input  logic signed [BEST_W-1:0] m_low_ask,
    input  logic [CNT_W-1:0]         m_level_count,
    input  logic                     m_dropped_oldest,
    output int                       errors,
    output int                       pending,
    output int                       drops_seen,
    output int                       rescans_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [BEST_W-1:0] bid;
        logic signed [BEST_W-1:0] ask;
        logic [CNT_W-1:0]         cnt;
        logic                     drop;
    } book_view_t;

    bit              present [2*TICKS];
    bit [PTR_W-1:0]  head_cnt [2*TICKS];
    bit [PTR_W-1:0]  tail_cnt [2*TICKS];
    int              best_buy;
    int              best_sell;
    book_view_t      expected_views [$];

    function automatic book_view_t apply_order(logic act, logic sd, logic [TICK_W-1:0] px);
        book_view_t v;
        int lv;
        int i;
        bit [PTR_W-1:0] q;
        v = '0;
        if (int'(px) < TICKS) begin
            lv = int'(sd) * TICKS + int'(px);
            if (act == ACT_ADD) begin
                if (!present[lv]) begin
                    present[lv] = 1;
                    head_cnt[lv] = '0;
                    tail_cnt[lv] = '0;
                end
                q = tail_cnt[lv] - head_cnt[lv];
                if (q >= LEVEL_DEPTH) begin
                    head_cnt[lv] = PTR_W'(head_cnt[lv] + 1'b1);
                    v.drop = 1;
                end
                tail_cnt[lv] = PTR_W'(tail_cnt[lv] + 1'b1);
                if (sd == SIDE_BUY) begin
                    if (best_buy < int'(px)) best_buy = int'(px);
                end else if (best_sell == -1 || best_sell > int'(px)) begin
                    best_sell = int'(px);
                end
            end else if (sd == SIDE_BUY && best_buy == int'(px)) begin
                best_buy = -1;
                for (i = int'(px) - 1; i >= 0; i--) begin
                    if (present[i]) begin
                        best_buy = i;
                        break;
                    end
                end
            end else if (sd == SIDE_SELL && best_sell == int'(px)) begin
                best_sell = -1;
                for (i = int'(px) + 1; i < TICKS; i++) begin
                    if (present[TICKS + i]) begin
                        best_sell = i;
                        break;
                    end
                end
            end
            if (present[lv]) begin
                q = tail_cnt[lv] - head_cnt[lv];
                v.cnt = q[CNT_W-1:0];
            end
        end
        v.bid = best_buy[BEST_W-1:0];
        v.ask = best_sell[BEST_W-1:0];
        return v;
    endfunction

    always @(posedge aclk) begin
        book_view_t e;
        if (!aresetn) begin
            foreach (present[k]) present[k] = 0;
            best_buy = -1;
            best_sell = -1;
            expected_views.delete();
            errors = 0;
            drops_seen = 0;
            rescans_seen = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_views.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    errors++;
                end else begin
                    e = expected_views.pop_front();
                    if (m_high_bid !== e.bid) begin
                        $error("high_bid expected %0d actual %0d", e.bid, m_high_bid);
                        errors++;
                    end
                    if (m_low_ask !== e.ask) begin
                        $error("low_ask expected %0d actual %0d", e.ask, m_low_ask);
                        errors++;
                    end
                    if (m_level_count !== e.cnt) begin
                        $error("level_count expected %0d actual %0d", e.cnt, m_level_count);
                        errors++;
                    end
                    if (m_dropped_oldest !== e.drop) begin
                        $error("dropped_oldest expected %0d actual %0d", e.drop,
                               m_dropped_oldest);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_action == ACT_EMPTY &&
                    ((s_side == SIDE_BUY && best_buy == int'(s_price_index)) ||
                     (s_side == SIDE_SELL && best_sell == int'(s_price_index))))
                    rescans_seen++;
                e = apply_order(s_action, s_side, s_price_index);
                if (e.drop) drops_seen++;
                expected_views.push_back(e);
            end
        end
        pending = expected_views.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the order book level insert testbench: clock, reset, stimulus and verdict.
// Depends on obl_pkg, obl_checker and order_book_level_insert_best_price_core.
module tb_top
    import obl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1180;
    localparam int LIMIT    = 2000000;

    logic                     aclk = 0;
    logic                     aresetn = 0;
    logic                     s_valid = 0;
    logic                     s_ready;
    logic                     s_action = 0;
    logic                     s_side = 0;
    logic [TICK_W-1:0]        s_price_index = '0;
    logic [ID_W-1:0]          s_order_id = '0;
    logic                     m_valid;
    logic                     m_ready = 0;
    logic signed [BEST_W-1:0] m_high_bid;
    logic signed [BEST_W-1:0] m_low_ask;
    logic [CNT_W-1:0]         m_level_count;
    logic                     m_dropped_oldest;
    int                       errors;
    int                       pending;
    int                       drops_seen;
    int                       rescans_seen;
    int                       cycles = 0;
    int                       sent = 0;
    bit                       hold_off = 0;
    bit                       stall_done = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    order_book_level_insert_best_price_core u_dut (.*);

    obl_checker u_chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** order_book_level_insert_best_price_core: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (sent == 300 && !stall_done) begin
            stall_done = 1;
            hold_off = 1;
            repeat (200) @(posedge aclk);
            hold_off = 0;
        end
    end

    initial begin
        int w;
        @(posedge aclk iff aresetn);
        forever begin
            w = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0 || hold_off) begin
                m_ready <= 0;
                repeat (w) @(posedge aclk);
                while (hold_off) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk iff m_valid);
        end
    end

    task automatic send_order(logic act, logic sd, logic [TICK_W-1:0] px, logic [ID_W-1:0] id,
                              int gap);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_action <= act;
        s_side <= sd;
        s_price_index <= px;
        s_order_id <= id;
        @(posedge aclk iff s_ready);
        sent++;
    endtask

    function automatic logic [TICK_W-1:0] last_top(bit sd);
        return sd ? m_low_ask[TICK_W-1:0] : m_high_bid[TICK_W-1:0];
    endfunction

    logic [TICK_W-1:0] hot_px [8];

    initial begin
        int i;
        int k;
        int r;
        int g;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_order(ACT_EMPTY, SIDE_BUY, 12'd0, '0, 0);
        send_order(ACT_EMPTY, SIDE_SELL, 12'hFFF, '1, 0);
        send_order(ACT_ADD, SIDE_BUY, 12'd0, 32'h0, 0);
        send_order(ACT_ADD, SIDE_BUY, 12'hFFF, 32'hFFFF_FFFF, 0);
        send_order(ACT_ADD, SIDE_SELL, 12'hFFF, 32'h5555_5555, 0);
        send_order(ACT_ADD, SIDE_SELL, 12'd0, 32'hAAAA_AAAA, 0);
        send_order(ACT_ADD, SIDE_BUY, 12'd100, 32'h1, 0);
        send_order(ACT_EMPTY, SIDE_BUY, 12'd100, '0, 0);
        send_order(ACT_EMPTY, SIDE_BUY, 12'hFFF, '0, 0);
        send_order(ACT_EMPTY, SIDE_SELL, 12'd0, '0, 0);
        send_order(ACT_EMPTY, SIDE_SELL, 12'hFFF, '0, 0);
        for (i = 0; i < 18; i++) send_order(ACT_ADD, SIDE_SELL, 12'd7, ID_W'(i), 0);
        send_order(ACT_EMPTY, SIDE_SELL, 12'd7, '0, 0);
        send_order(ACT_EMPTY, SIDE_BUY, 12'd0, '0, 0);
        send_order(ACT_EMPTY, SIDE_BUY, 12'd0, '0, 0);
        for (i = 0; i < 8; i++) hot_px[i] = TICK_W'($urandom_range(0, 4095));
        for (i = 0; i < N_RANDOM; i++) begin
            if (i == 600) begin
                s_valid <= 0;
                while (pending != 0) @(posedge aclk);
                repeat (100) @(posedge aclk);
            end
            g = $urandom_range(0, 13);
            if ((i / 150) % 2 == 1) g = 0;
            r = $urandom_range(0, 9);
            k = $urandom_range(0, 7);
            if (r < 5)
                send_order(ACT_ADD, 1'($urandom_range(0, 1)),
                           TICK_W'(hot_px[k] + TICK_W'($urandom_range(0, 3))),
                           ID_W'($urandom), g);
            else if (r < 8)
                send_order(ACT_EMPTY, 1'($urandom_range(0, 1)),
                           (r == 5) ? last_top(1'($urandom_range(0, 1))) : hot_px[k], '0, g);
            else
                send_order(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           TICK_W'($urandom_range(0, 4095)), ID_W'($urandom), g);
        end
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("Sent %0d transactions: %0d full-level drops, %0d best-price rescans.",
                 sent, drops_seen, rescans_seen);
        if (errors == 0)
            $display("** order_book_level_insert_best_price_core: PASSED **");
        else
            $display("** order_book_level_insert_best_price_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/obl_pkg.sv
hdl/obl_ram.sv
hdl/obl_ctrl.sv
hdl/obl_dp.sv
hdl/order_book_level_insert_best_price_core.sv
tb/sv/obl_checker.sv
tb/sv/tb_top.sv
